FILE: hw/rtl/car_pkg.sv
// ----------------------------------------------------------------------------
// car_pkg: shared types and constants of the common average reference block
// Field widths, the configuration reset value and the job record that the
// front end hands to the back end through the job queue.
// ----------------------------------------------------------------------------
package car_pkg;

  // Largest channel count the block is built for, and the default.
  localparam int MAX_CHANNELS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // Field widths, sized for the largest supported channel count.
  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 25;
  localparam int CHIDX_W  = 6;
  localparam int CNT_W    = 7;
  localparam int SUM_W    = 30;

  // Quotient bits resolved per cycle by the mean divider.
  localparam int DIV_RADIX_BITS = 4;

  // Channel count after reset.
  localparam logic [CNT_W-1:0] CFG_COUNT_RESET = 7'd8;

  // One job per accepted transaction: an optional emit of the held instant,
  // the store of the new sample, and an optional mean computation.
  typedef struct packed {
    logic                       emit;
    logic [CHIDX_W-1:0]         emit_idx;
    logic                       emit_last;
    logic                       emit_bank;
    logic                       wr_bank;
    logic [CHIDX_W-1:0]         wr_idx;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       done;
    logic signed [SUM_W-1:0]    sum;
    logic [CNT_W-1:0]           count;
  } job_t;

endpackage

FILE: hw/rtl/car_in_if.sv
// ----------------------------------------------------------------------------
// car_in_if: sample input channel
// Valid/ready channel carrying one channel sample per transaction.
// ----------------------------------------------------------------------------
interface car_in_if;

  logic                                 valid;
  logic                                 ready;
  logic signed [car_pkg::SAMPLE_W-1:0]  sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);

endinterface

FILE: hw/rtl/car_out_if.sv
// ----------------------------------------------------------------------------
// car_out_if: referenced result channel
// Valid/ready channel carrying one re-referenced sample per transaction.
// ----------------------------------------------------------------------------
interface car_out_if;

  logic                               valid;
  logic                               ready;
  logic signed [car_pkg::OUT_W-1:0]   referenced_value;
  logic [car_pkg::CHIDX_W-1:0]        channel_index;
  logic                               last_channel;

  modport source (output valid, output referenced_value, output channel_index,
                  output last_channel, input ready);
  modport sink   (input valid, input referenced_value, input channel_index,
                  input last_channel, output ready);

endinterface

FILE: hw/rtl/car_fifo.sv
// ----------------------------------------------------------------------------
// car_fifo: job queue between front end and back end
// Small register FIFO of job records; full and empty are exact.
// ----------------------------------------------------------------------------
module car_fifo #(
  parameter int DEPTH = car_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  car_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output car_pkg::job_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  car_pkg::job_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  // Handshake decode.
  assign push_ready = (fill_r != CNT_W'(DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill level update with wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/car_front.sv
// ----------------------------------------------------------------------------
// car_front: transaction intake and instant bookkeeping
// Accepts samples, keeps the running sum and channel counters, decides which
// held result each transaction releases and when an instant completes.
// ----------------------------------------------------------------------------
module car_front #(
  parameter int MAX_CHANNELS = car_pkg::MAX_CHANNELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [car_pkg::CNT_W-1:0] cfg_wr_data,
  car_in_if.sink                    in_chan,
  output logic                      job_valid,
  input  logic                      job_ready,
  output car_pkg::job_t             job
);

  localparam int IDX_W  = $clog2(MAX_CHANNELS);
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int LSUM_W = car_pkg::SAMPLE_W + IDX_W;

  logic [car_pkg::CNT_W-1:0] chan_count_r;
  logic signed [LSUM_W-1:0]  sum_r;
  logic signed [LSUM_W-1:0]  sum_inc;
  logic [CNT_W-1:0]          recv_r;
  logic [CNT_W-1:0]          recv_inc;
  logic [CNT_W-1:0]          need;
  logic [CNT_W-1:0]          held_cnt_r;
  logic [CNT_W-1:0]          emit_idx_r;
  logic [CNT_W-1:0]          emit_idx_inc;
  logic                      emit_pend_r;
  logic                      coll_bank_r;
  logic                      emit_now;
  logic                      complete;
  logic                      accept;

  // Transactions pass straight into the job queue.
  assign in_chan.ready = job_ready;
  assign job_valid     = in_chan.valid;
  assign accept        = in_chan.valid && job_ready;

  // Effective channel count: zero means one, large values clamp.
  always_comb begin
    if (chan_count_r == '0) begin
      need = CNT_W'(1);
    end else if (chan_count_r > car_pkg::CNT_W'(MAX_CHANNELS)) begin
      need = CNT_W'(MAX_CHANNELS);
    end else begin
      need = CNT_W'(chan_count_r);
    end
  end

  // Classification of the current transaction.
  assign emit_now     = emit_pend_r && (emit_idx_r < held_cnt_r);
  assign emit_idx_inc = emit_idx_r + 1'b1;
  assign recv_inc     = recv_r + 1'b1;
  assign sum_inc      = sum_r + LSUM_W'(in_chan.sample_value);
  assign complete     = (recv_inc >= need);

  // Job record for the back end.
  always_comb begin
    job.emit      = emit_now;
    job.emit_idx  = car_pkg::CHIDX_W'(emit_idx_r);
    job.emit_last = (emit_idx_inc == held_cnt_r);
    job.emit_bank = ~coll_bank_r;
    job.wr_bank   = coll_bank_r;
    job.wr_idx    = car_pkg::CHIDX_W'(recv_r);
    job.sample    = in_chan.sample_value;
    job.done      = complete;
    job.sum       = car_pkg::SUM_W'(sum_inc);
    job.count     = car_pkg::CNT_W'(recv_inc);
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= car_pkg::CFG_COUNT_RESET;
    end else if (cfg_wr_en) begin
      chan_count_r <= cfg_wr_data;
    end
  end

  // Collection and emit bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      recv_r      <= '0;
      held_cnt_r  <= '0;
      emit_idx_r  <= '0;
      emit_pend_r <= 1'b0;
      coll_bank_r <= 1'b0;
    end else if (accept) begin
      if (complete) begin
        // Instant closes: the collecting bank becomes the emit bank, and
        // anything left of the previous instant is dropped.
        held_cnt_r  <= recv_inc;
        emit_idx_r  <= '0;
        emit_pend_r <= 1'b1;
        sum_r       <= '0;
        recv_r      <= '0;
        coll_bank_r <= ~coll_bank_r;
      end else begin
        if (emit_now) begin
          emit_idx_r <= emit_idx_inc;
          if (emit_idx_inc >= held_cnt_r) begin
            emit_pend_r <= 1'b0;
          end
        end
        sum_r  <= sum_inc;
        recv_r <= recv_inc;
      end
    end
  end

endmodule

FILE: hw/rtl/car_back.sv
// ----------------------------------------------------------------------------
// car_back: sample store, mean divider and result output
// Executes jobs in order: stores samples in a two-bank memory, reads the
// held instant, subtracts the mean and computes each new mean serially.
// ----------------------------------------------------------------------------
module car_back #(
  parameter int MAX_CHANNELS = car_pkg::MAX_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  car_pkg::job_t job,
  car_out_if.source     out_chan
);

  localparam int IDX_W     = $clog2(MAX_CHANNELS);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int RADIX     = car_pkg::DIV_RADIX_BITS;
  localparam int DIV_STEPS = (car_pkg::SUM_W + RADIX - 1) / RADIX;
  localparam int DIV_W     = DIV_STEPS * RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int REM_W     = car_pkg::CNT_W;
  localparam int SW        = car_pkg::SAMPLE_W;
  localparam int OW        = car_pkg::OUT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_DIV
  } state_t;

  state_t                     state_r;
  car_pkg::job_t              job_r;
  logic signed [SW-1:0]       mem [MEM_DEPTH];
  logic signed [SW-1:0]       rd_data_r;
  logic signed [OW-1:0]       held_mean_r;
  logic                       out_valid_r;
  logic signed [OW-1:0]       out_value_r;
  logic [car_pkg::CHIDX_W-1:0] out_idx_r;
  logic                       out_last_r;
  logic                       pop;
  logic                       out_free;
  logic                       out_load;
  logic signed [OW-1:0]       diff;
  logic [ADDR_W-1:0]          wr_addr;
  logic [ADDR_W-1:0]          rd_addr;

  // Divider state.
  car_pkg::job_t              div_src;
  logic [DIV_W-1:0]           quo_r, quo_nxt;
  logic [REM_W-1:0]           rem_r, rem_nxt;
  logic [REM_W-1:0]           dvsr_r;
  logic                       neg_r;
  logic [STEP_W-1:0]          step_r;
  logic [car_pkg::SUM_W-1:0]  sum_mag;
  logic [REM_W:0]             trial;
  logic signed [OW-1:0]       mean_mag;
  logic signed [OW-1:0]       mean_val;

  assign job_ready = (state_r == ST_IDLE);
  assign pop       = job_valid && job_ready;
  assign out_free  = !out_valid_r || out_chan.ready;
  assign out_load  = (state_r == ST_EMIT) && out_free;
  assign wr_addr   = {job.wr_bank, job.wr_idx[IDX_W-1:0]};
  assign rd_addr   = {job.emit_bank, job.emit_idx[IDX_W-1:0]};
  assign diff      = OW'(rd_data_r) - held_mean_r;

  // Result channel.
  assign out_chan.valid            = out_valid_r;
  assign out_chan.referenced_value = out_value_r;
  assign out_chan.channel_index    = out_idx_r;
  assign out_chan.last_channel     = out_last_r;

  // While idle the divider follows the incoming job, otherwise the held one.
  assign div_src = (state_r == ST_IDLE) ? job : job_r;

  // Magnitude of the instant's sum; the sign is applied after division.
  assign sum_mag = div_src.sum[car_pkg::SUM_W-1] ? car_pkg::SUM_W'(-div_src.sum)
                                                  : car_pkg::SUM_W'(div_src.sum);

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    trial   = '0;
    for (int i = 0; i < RADIX; i++) begin
      trial   = {rem_nxt, quo_nxt[DIV_W-1]};
      quo_nxt = {quo_nxt[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvsr_r}) begin
        trial      = trial - {1'b0, dvsr_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[REM_W-1:0];
    end
  end

  // Signed mean, truncated toward zero.
  assign mean_mag = {1'b0, quo_nxt[OW-2:0]};
  assign mean_val = neg_r ? -mean_mag : mean_mag;

  // Two-bank sample memory: write the collecting bank, read the emit bank.
  always_ff @(posedge clk) begin
    if (pop) begin
      mem[wr_addr] <= job.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && job.emit) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Job sequencer with the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      held_mean_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            job_r <= job;
            if (job.emit) begin
              state_r <= ST_EMIT;
            end else if (job.done) begin
              state_r <= ST_DIV;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_value_r <= diff;
            out_idx_r   <= job_r.emit_idx;
            out_last_r  <= job_r.emit_last;
            state_r     <= job_r.done ? ST_DIV : ST_IDLE;
          end
        end
        ST_DIV: begin
          if (step_r == '0) begin
            held_mean_r <= mean_val;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider operands load outside ST_DIV and step during ST_DIV.
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r - 1'b1;
    end else begin
      quo_r  <= DIV_W'(sum_mag);
      rem_r  <= '0;
      dvsr_r <= div_src.count;
      neg_r  <= div_src.sum[car_pkg::SUM_W-1];
      step_r <= STEP_W'(DIV_STEPS - 1);
    end
  end

endmodule

FILE: hw/rtl/common_average_reference.sv
// ----------------------------------------------------------------------------
// common_average_reference: common average re-referencing of sample streams
//
//   Channel   Direction  Handshake    Payload
//   in_chan   input      valid/ready  sample_value (s24)
//   out_chan  output     valid/ready  referenced_value (s25), channel_index,
//                                     last_channel
//   cfg_*     input      write enable channel_count (u7)
//
// In the back end a transaction is popped with its memory read; one that
// releases a result then subtracts into the output register in ST_EMIT.
// The last channel of an instant adds one mean division (4 quotient bits
// per cycle). A 4-entry job queue lets the intake run ahead of the back
// end. Reset is synchronous and needs no clearing pass; the sample memory
// is read only at entries written in the same instant. A stalled result
// channel stalls the back end only; intake stops once the job queue is full.
// ----------------------------------------------------------------------------
module common_average_reference #(
  parameter int MAX_CHANNELS = car_pkg::MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = car_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [car_pkg::CNT_W-1:0] cfg_wr_data,
  car_in_if.sink                    in_chan,
  car_out_if.source                 out_chan
);

  logic          push_valid;
  logic          push_ready;
  car_pkg::job_t push_job;
  logic          pop_valid;
  logic          pop_ready;
  car_pkg::job_t pop_job;

  // Intake and classification.
  car_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .job_valid   (push_valid),
    .job_ready   (push_ready),
    .job         (push_job)
  );

  // Job queue.
  car_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_job)
  );

  // Storage, division and result output.
  car_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .out_chan  (out_chan)
  );

endmodule

FILE: bench/car_checker.sv
// ----------------------------------------------------------------------------
// car_checker: scoreboard for the common average reference block
// Watches the configuration port and both channels. Each accepted sample
// transaction updates a cycle-free predictor of the block. The predictor
// queues the re-referenced result that the sample releases, and each accepted
// result transaction is compared field by field with the oldest queued entry.
// ----------------------------------------------------------------------------
module car_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [car_pkg::CNT_W-1:0] cfg_wr_data,
  car_in_if                         in_mon,
  car_out_if                        out_mon,
  output int                        fail_count,
  output int                        expected_count,
  output int                        result_count
);

  localparam int MAX_CH = car_pkg::MAX_CHANNELS_DEF;

  typedef struct {
    logic signed [car_pkg::OUT_W-1:0] value;
    logic [car_pkg::CHIDX_W-1:0]      index;
    logic                             last;
  } referenced_t;

  // Results that accepted samples have released but that have not come out yet.
  referenced_t referenced_q[$];

  // Predictor state: collecting side and emitting side of the double buffer.
  logic [car_pkg::CNT_W-1:0]           channel_count;
  logic signed [car_pkg::SAMPLE_W-1:0] collect_bank [MAX_CH];
  logic signed [car_pkg::SAMPLE_W-1:0] emit_bank    [MAX_CH];
  longint                              instant_sum;
  int                                  received;
  longint                              held_mean;
  int                                  held_count;
  int                                  emit_idx;
  bit                                  emit_pending;

  // A count of 0 means one channel; counts above the build size saturate.
  function automatic int effective_count(logic [car_pkg::CNT_W-1:0] c);
    if (c == 0) return 1;
    if (int'(c) > MAX_CH) return MAX_CH;
    return int'(c);
  endfunction

  // One sample step: release the next result of the held instant first, then
  // collect the sample and close the instant once enough channels are in.
  function void rereference_sample(logic signed [car_pkg::SAMPLE_W-1:0] sample);
    referenced_t r;
    longint      diff;
    if (emit_pending && emit_idx < held_count) begin
      diff    = longint'(emit_bank[emit_idx]) - held_mean;
      r.value = diff[car_pkg::OUT_W-1:0];
      r.index = emit_idx[car_pkg::CHIDX_W-1:0];
      r.last  = (emit_idx + 1 == held_count);
      referenced_q.push_back(r);
      emit_idx++;
      if (emit_idx >= held_count) emit_pending = 0;
    end
    if (received < MAX_CH) begin
      collect_bank[received] = sample;
      instant_sum += longint'(sample);
      received++;
    end
    // Closing an instant drops whatever the previous one had left to emit.
    if (received >= effective_count(channel_count)) begin
      held_mean    = instant_sum / longint'(received);
      held_count   = received;
      emit_bank    = collect_bank;
      emit_idx     = 0;
      emit_pending = 1;
      instant_sum  = 0;
      received     = 0;
    end
  endfunction

  // Monitor and compare on every rising edge.
  always @(posedge clk) begin
    referenced_t exp_r;
    if (!rst_n) begin
      channel_count = car_pkg::CFG_COUNT_RESET;
      for (int i = 0; i < MAX_CH; i++) begin
        collect_bank[i] = '0;
        emit_bank[i]    = '0;
      end
      instant_sum  = 0;
      received     = 0;
      held_mean    = 0;
      held_count   = 0;
      emit_idx     = 0;
      emit_pending = 0;
      fail_count   = 0;
      result_count = 0;
      referenced_q.delete();
    end else begin
      if (cfg_wr_en) channel_count = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) rereference_sample(in_mon.sample_value);
      if (out_mon.valid && out_mon.ready) begin
        result_count++;
        if (referenced_q.size() == 0) begin
          $error("unexpected result transaction: channel_index %0d referenced_value %0d",
                 out_mon.channel_index, out_mon.referenced_value);
          fail_count++;
        end else begin
          exp_r = referenced_q.pop_front();
          if (out_mon.referenced_value !== exp_r.value) begin
            $error("referenced_value: expected %0d, actual %0d",
                   exp_r.value, out_mon.referenced_value);
            fail_count++;
          end
          if (out_mon.channel_index !== exp_r.index) begin
            $error("channel_index: expected %0d, actual %0d",
                   exp_r.index, out_mon.channel_index);
            fail_count++;
          end
          if (out_mon.last_channel !== exp_r.last) begin
            $error("last_channel: expected %0d, actual %0d",
                   exp_r.last, out_mon.last_channel);
            fail_count++;
          end
        end
      end
    end
    expected_count = referenced_q.size();
  end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: top level of the common average reference testbench
// Drives samples and channel-count writes into the block, lets the result
// channel stall at random and hands all checking to car_checker. A short
// directed run covers field extremes, rounding toward zero, a count lowered in
// the middle of an instant and an instant closed while the previous one is
// still being emitted. Random segments then sweep many counts under four
// flow-control phases.
// ----------------------------------------------------------------------------
module tb;

  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum int {VALUES_FULL, VALUES_EXTREME, VALUES_SMALL} value_style_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [car_pkg::CNT_W-1:0] cfg_wr_data;

  car_in_if  in_chan ();
  car_out_if out_chan ();

  int idle_pct;
  int stall_pct;
  int fail_count;
  int expected_count;
  int result_count;
  int samples_sent;
  int count_writes;
  int cycles = 0;

  common_average_reference dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  car_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .fail_count     (fail_count),
    .expected_count (expected_count),
    .result_count   (result_count)
  );

  always #1 clk = ~clk;

  // Result channel back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Drop valid and wait until every released result has come out, then give
  // an instant that is still being divided time to settle.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_channel_count(input int value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[car_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    count_writes++;
  endtask

  // One sample transaction, with random sender gaps in front of it.
  task automatic send_sample(input int value);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample_value <= value[car_pkg::SAMPLE_W-1:0];
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    samples_sent++;
    @(negedge clk);
  endtask

  function automatic int sample_for(value_style_t style);
    int pick;
    pick = $urandom_range(0, 5);
    case (style)
      VALUES_FULL: return $urandom;
      VALUES_EXTREME: begin
        case (pick)
          0, 1:    return -8388608;
          2, 3:    return 8388607;
          4:       return 0;
          default: return -1;
        endcase
      end
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  initial begin : stimulus
    int           idle_tbl [4];
    int           stall_tbl [4];
    int           count;
    int           eff;
    int           n_items;
    value_style_t style;

    idle_tbl  = '{0, 67, 0, 31};
    stall_tbl = '{0, 0, 67, 31};

    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_chan.valid        = 1'b0;
    in_chan.sample_value = '0;
    idle_pct             = 0;
    stall_pct            = 0;
    samples_sent         = 0;
    count_writes         = 0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default count of 8, but only five channels before the count drops to 3:
    // the next sample closes a six-channel instant.
    send_sample(8388607);
    send_sample(-8388608);
    send_sample(0);
    send_sample(-1);
    send_sample(1);
    set_channel_count(3);
    send_sample(123);
    // The three-channel instant closes while the six-channel one is half out.
    send_sample(-3);
    send_sample(0);
    send_sample(0);
    // Two channels: a mean of -1.5 must truncate to -1, then the extremes.
    set_channel_count(2);
    send_sample(-3);
    send_sample(0);
    send_sample(8388607);
    send_sample(-8388608);
    // Count 0 behaves as a single channel.
    set_channel_count(0);
    send_sample(5);
    send_sample(-8388608);
    send_sample(8388607);
    // A count above the build size saturates at the maximum.
    set_channel_count(127);
    for (int i = 0; i < 64; i++) send_sample(i[0] ? 8388607 : -8388608);
    send_sample(-8388608);

    // Random segments: a new count per segment, mostly whole instants with a
    // partial one left over now and then.
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_tbl[phase];
      stall_pct = stall_tbl[phase];
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(0, 9))
          0:       count = 0;
          1:       count = 1;
          2:       count = 64;
          3:       count = 127;
          4:       count = $urandom_range(65, 127);
          5:       count = $urandom_range(0, 127);
          default: count = $urandom_range(2, 12);
        endcase
        eff     = (count == 0) ? 1 :
                  (count > car_pkg::MAX_CHANNELS_DEF) ? car_pkg::MAX_CHANNELS_DEF : count;
        n_items = eff * ((44 + eff - 1) / eff);
        if (eff > 1 && $urandom_range(0, 3) == 0) n_items += $urandom_range(1, eff - 1);
        style = value_style_t'($urandom_range(0, 2));
        set_channel_count(count);
        for (int i = 0; i < n_items; i++) send_sample(sample_for(style));
      end
    end

    wait_drained();
    $display("Summary: %0d samples sent and %0d results checked over %0d count writes,",
             samples_sent, result_count, count_writes);
    $display("with counts 0 to 127 under free flow, sender gaps, receiver stalls and both.");
    if (fail_count == 0 && expected_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/car_pkg.sv
hw/rtl/car_in_if.sv
hw/rtl/car_out_if.sv
hw/rtl/car_fifo.sv
hw/rtl/car_front.sv
hw/rtl/car_back.sv
hw/rtl/common_average_reference.sv
bench/car_checker.sv
bench/tb.sv
